// ----- rtl/rafb_pkg.sv -----
// Shared types and constants for the RFID ASCII-hex frame builder.
package rafb_pkg;

  // Characters per tag ID frame, and the width of the position counter.
  localparam int unsigned IdChars = 10;
  localparam int unsigned PosW    = 5;

  localparam logic [7:0] StartByte = 8'h02;
  localparam logic [7:0] StopByte  = 8'h03;
  localparam logic [7:0] CharA     = 8'h41;  // 'A'
  localparam logic [7:0] AlphaOfs  = 8'd55;  // 'A' - 10
  localparam logic [7:0] DigitOfs  = 8'd48;  // '0'

  // Most words one character can cause, and the width of a word count.
  localparam int unsigned MaxWords = 4;
  localparam int unsigned CntW     = 3;

  localparam logic [15:0][7:0] HexDigits = {
    8'h46, 8'h45, 8'h44, 8'h43, 8'h42, 8'h41, 8'h39, 8'h38,
    8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
  };

  // Frame state carried from one character to the next.
  typedef struct packed {
    logic [PosW-1:0] pos;
    logic [7:0]      csum;
    logic [3:0]      hi_nib;
  } rafb_state_t;

  // Words caused by one character, first word in entry 0.
  typedef struct packed {
    logic [MaxWords-1:0][7:0] words;
    logic [CntW-1:0]          count;
    logic                     stop;
  } rafb_bundle_t;

endpackage

// ----- rtl/rfid_ascii_hex_frame_builder_core.sv -----
// Top level: RFID ASCII-hex frame builder with XOR checksum, stream ports.
// The first word of a character appears in the cycle after it is taken.
// Throughput: one output word per cycle while m_axis_tready is high; a character
//   yields 1, 2 or 4 words (4 for the frame's last one).
// The next character is taken in the cycle the previous one's last word leaves.
// Reset (rst_ni low, async) clears frame position, checksum, nibble and buffer word count.
module rfid_ascii_hex_frame_builder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] id_char
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] tx_byte
  output logic       m_axis_tlast,   // run_last
  output logic       m_axis_tuser    // [0] frame_end
);
  import rafb_pkg::*;

  rafb_state_t  state_q, state_d;
  rafb_bundle_t bundle;

  // Output buffer: words of the current character, head word in entry 0.
  logic [MaxWords-1:0][7:0] words_q;
  logic [CntW-1:0]          rem_q;
  logic                     stop_q;

  logic in_fire;
  logic out_fire;

  rafb_encode u_encode (
    .char_i   (s_axis_tdata),
    .state_i  (state_q),
    .state_o  (state_d),
    .bundle_o (bundle)
  );

  assign out_fire = m_axis_tvalid && m_axis_tready;
  // Take a new character when the buffer is empty or its last word leaves now.
  assign s_axis_tready = (rem_q == '0) || ((rem_q == CntW'(1)) && m_axis_tready);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = (rem_q != '0);
  assign m_axis_tdata  = words_q[0];
  assign m_axis_tlast  = (rem_q == CntW'(1));
  assign m_axis_tuser  = stop_q && (rem_q == CntW'(1));

  // Advance frame state on each taken character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      stop_q <= 1'b0;
    end else if (in_fire) begin
      rem_q  <= bundle.count;
      stop_q <= bundle.stop;
    end else if (out_fire) begin
      rem_q  <= rem_q - CntW'(1);
    end
  end

  // Load the bundle, or shift the next word to the head.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      words_q <= bundle.words;
    end else if (out_fire) begin
      words_q <= {8'h00, words_q[MaxWords-1:1]};
    end
  end

endmodule

// ----- rtl/rafb_encode.sv -----
// Per-character frame logic: decode, checksum update and output word bundle.
module rafb_encode (
  input  logic [7:0]            char_i,
  input  rafb_pkg::rafb_state_t state_i,
  output rafb_pkg::rafb_state_t state_o,
  output rafb_pkg::rafb_bundle_t bundle_o
);
  import rafb_pkg::*;

  logic [PosW-1:0] pos;
  logic [7:0]      dec;
  logic [7:0]      csum_new;
  logic            is_first;
  logic            is_last;

  always_comb begin
    pos = (state_i.pos >= PosW'(IdChars)) ? '0 : state_i.pos;
    dec = (char_i >= CharA) ? char_i - AlphaOfs : char_i - DigitOfs;
    is_first = (pos == '0);
    is_last  = (pos == PosW'(IdChars - 1));

    // Odd position closes a pair; even position opens one.
    if (pos[0]) begin
      csum_new       = state_i.csum ^ ({state_i.hi_nib, 4'h0} | dec);
      state_o.hi_nib = state_i.hi_nib;
    end else begin
      csum_new       = state_i.csum;
      state_o.hi_nib = dec[3:0];
    end

    state_o.pos  = is_last ? '0 : pos + PosW'(1);
    state_o.csum = is_last ? '0 : csum_new;

    bundle_o.words = '0;
    bundle_o.stop  = 1'b0;
    if (is_first) begin
      bundle_o.words[0] = StartByte;
      bundle_o.words[1] = char_i;
      bundle_o.count    = CntW'(2);
    end else if (is_last) begin
      bundle_o.words[0] = char_i;
      bundle_o.words[1] = HexDigits[csum_new[7:4]];
      bundle_o.words[2] = HexDigits[csum_new[3:0]];
      bundle_o.words[3] = StopByte;
      bundle_o.count    = CntW'(4);
      bundle_o.stop     = 1'b1;
    end else begin
      bundle_o.words[0] = char_i;
      bundle_o.count    = CntW'(1);
    end
  end

endmodule
